@@ src/positional_ordered_list_engine_unit_macros.svh @@
// Assertion macros for the positional ordered list engine.
// Used by the top level; expects signals clk and rst in scope.
`ifndef POSITIONAL_ORDERED_LIST_ENGINE_UNIT_MACROS_SVH
`define POSITIONAL_ORDERED_LIST_ENGINE_UNIT_MACROS_SVH

// cond implies conseq in the same cycle
`define POLE_ASSERT_NOW(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
    else $error(msg);

// cond implies nxt in the following cycle
`define POLE_ASSERT_NEXT(label, cond, nxt, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (nxt)) \
    else $error(msg);

`endif

@@ src/pole_pkg.sv @@
// Shared types and codes of the positional ordered list engine.
// No dependencies.
`timescale 1ns / 1ps

package pole_pkg;

  localparam int ACTION_W = 2;
  localparam int POS_W    = 7;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;

  typedef enum logic [ACTION_W-1:0] {
    ACT_INSERT = 2'd0,
    ACT_DELETE = 2'd1,
    ACT_GET    = 2'd2,
    ACT_LOCATE = 2'd3
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_BADPOS = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

  // broadcast command to every cell
  typedef struct packed {
    logic ins;
    logic del;
    logic loc;
  } cell_cmd_t;

  // scan wave flag and position travelling down the chain
  typedef struct packed {
    logic             hit;
    logic [POS_W-1:0] fpos;
  } scan_t;

endpackage

@@ src/pole_stream_if.sv @@
// Request and response channel interfaces of the list engine.
// Depends on pole_pkg for field widths.
`timescale 1ns / 1ps

interface pole_req_if import pole_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [POS_W-1:0]    position;
  logic [VALUE_W-1:0]  element_value;

  modport source (output valid, action, position, element_value, input ready);
  modport sink   (input valid, action, position, element_value, output ready);
endinterface

interface pole_rsp_if import pole_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [VALUE_W-1:0]  read_value;
  logic [POS_W-1:0]    found_position;
  logic [POS_W-1:0]    list_length;

  modport source (output valid, status, read_value, found_position, list_length,
                  input ready);
  modport sink   (input valid, status, read_value, found_position, list_length,
                  output ready);
endinterface

@@ src/positional_ordered_list_engine_unit.sv @@
// Positional ordered list engine: a chain of CAPACITY cells with a sequencer.
// Insert shifts the cells in the evaluate state. Delete, get, locate: the scan
// wave crosses the chain one cell per cycle in the scan state; errors skip it.
// Done waits for a free response channel; requests are taken only in idle.
// Reset (rst, synchronous) empties the list; element storage is not cleared.
// Depends on pole_pkg, pole_stream_if, pole_cell and the assertion macros.
`timescale 1ns / 1ps

module positional_ordered_list_engine_unit import pole_pkg::*; #(
  parameter int CAPACITY   = 64,
  parameter int DATA_WIDTH = 32
) (
  input logic       clk,
  input logic       rst,
  pole_req_if.sink  req,
  pole_rsp_if.source rsp
);

  `include "positional_ordered_list_engine_unit_macros.svh"

  localparam int IW   = $clog2(CAPACITY);
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = ((CW > POS_W) ? CW : POS_W) + 1;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EVAL = 4'b0010,
    S_SCAN = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t                state;
  logic [IW-1:0]         ctr;
  logic [CW-1:0]         count;
  logic                  out_valid;

  action_t               req_action;
  logic [POS_W-1:0]      req_pos;
  logic [DATA_WIDTH-1:0] req_val;

  status_t               res_status;
  logic [DATA_WIDTH-1:0] res_value;
  logic [POS_W-1:0]      res_found;

  status_t               out_status;
  logic [VALUE_W-1:0]    out_value;
  logic [POS_W-1:0]      out_found;
  logic [POS_W-1:0]      out_length;

  logic [CMPW-1:0]       pos_x;
  logic [CMPW-1:0]       n_x;
  logic [IW-1:0]         tgt;
  logic                  ins_bad;
  logic                  full;
  status_t               eval_status;
  logic                  eval_scan;
  logic                  ctr_done;
  logic                  load_out;
  cell_cmd_t             cmd;

  scan_t                 scan_bus [CAPACITY+1];
  logic [DATA_WIDTH-1:0] scan_val [CAPACITY+1];
  logic [DATA_WIDTH-1:0] cell_data [CAPACITY];

  assign req.ready = (state == S_IDLE) && !rst;
  assign rsp.valid          = out_valid;
  assign rsp.status         = out_status;
  assign rsp.read_value     = out_value;
  assign rsp.found_position = out_found;
  assign rsp.list_length    = out_length;

  assign pos_x    = CMPW'(req_pos);
  assign n_x      = CMPW'(count);
  assign tgt      = IW'(pos_x - CMPW'(1));
  assign ins_bad  = (req_pos == '0) || (pos_x > n_x + CMPW'(1));
  assign full     = (count == CW'(CAPACITY));
  assign ctr_done = (ctr == IW'(CAPACITY - 1));
  assign load_out = (state == S_DONE) && (!out_valid || rsp.ready);

  always_comb begin
    eval_status = ST_OK;
    eval_scan   = 1'b0;
    case (req_action)
      ACT_INSERT: begin
        if (ins_bad) begin
          eval_status = ST_BADPOS;
        end else if (full) begin
          eval_status = ST_FULL;
        end
      end
      ACT_DELETE, ACT_GET: begin
        if (count == '0) begin
          eval_status = ST_EMPTY;
        end else if ((req_pos == '0) || (pos_x > n_x)) begin
          eval_status = ST_BADPOS;
        end else begin
          eval_scan = 1'b1;
        end
      end
      default: begin
        eval_scan = 1'b1;
      end
    endcase
  end

  always_comb begin
    cmd.ins = (state == S_EVAL) && (req_action == ACT_INSERT) && (eval_status == ST_OK);
    cmd.del = (state == S_SCAN) && ctr_done && (req_action == ACT_DELETE);
    cmd.loc = (req_action == ACT_LOCATE);
  end

  assign scan_bus[0] = '0;
  assign scan_val[0] = '0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_d;
    logic [DATA_WIDTH-1:0] right_d;

    if (i == 0) begin : g_first
      assign left_d = '0;
    end else begin : g_mid
      assign left_d = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_d = '0;
    end else begin : g_inner
      assign right_d = cell_data[i+1];
    end

    pole_cell #(
      .CAPACITY  (CAPACITY),
      .DATA_WIDTH(DATA_WIDTH),
      .INDEX     (i)
    ) u_cell (
      .clk           (clk),
      .cmd           (cmd),
      .tgt           (tgt),
      .cnt           (count),
      .val           (req_val),
      .left_value    (left_d),
      .right_value   (right_d),
      .cell_value    (cell_data[i]),
      .scan_in       (scan_bus[i]),
      .scan_in_value (scan_val[i]),
      .scan_out      (scan_bus[i+1]),
      .scan_out_value(scan_val[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      ctr       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready && !load_out) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            state <= S_EVAL;
          end
        end
        S_EVAL: begin
          ctr <= '0;
          if (cmd.ins) begin
            count <= count + CW'(1);
          end
          state <= eval_scan ? S_SCAN : S_DONE;
        end
        S_SCAN: begin
          ctr <= ctr + IW'(1);
          if (ctr_done) begin
            if (cmd.del) begin
              count <= count - CW'(1);
            end
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (load_out) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      req_action <= action_t'(req.action);
      req_pos    <= req.position;
      req_val    <= DATA_WIDTH'(req.element_value);
    end
    if (state == S_EVAL) begin
      res_status <= eval_status;
      res_value  <= '0;
      res_found  <= '0;
    end
    if ((state == S_SCAN) && ctr_done) begin
      if (req_action == ACT_LOCATE) begin
        res_value <= '0;
        res_found <= scan_bus[CAPACITY].hit ? scan_bus[CAPACITY].fpos : '0;
      end else begin
        res_value <= scan_bus[CAPACITY].hit ? scan_val[CAPACITY] : '0;
        res_found <= '0;
      end
    end
    if (load_out) begin
      out_status <= res_status;
      out_value  <= VALUE_W'(res_value);
      out_found  <= res_found;
      out_length <= POS_W'(count);
    end
  end

  `POLE_ASSERT_NOW(a_count_bound, 1'b1, count <= CW'(CAPACITY), "element count above capacity")
  `POLE_ASSERT_NEXT(a_count_hold, (state == S_IDLE) || (state == S_DONE), $stable(count), "count moved outside an update")
  `POLE_ASSERT_NOW(a_rsp_from_done, $rose(out_valid), $past(state) == S_DONE, "response raised outside done")
  `POLE_ASSERT_NOW(a_scan_hits, (state == S_SCAN) && ctr_done && (req_action != ACT_LOCATE), scan_bus[CAPACITY].hit, "positional scan missed its cell")

endmodule

@@ src/pole_cell.sv @@
// One storage cell of the list chain: holds one element, shifts with its
// neighbors on insert/delete and forwards the scan wave. Depends on pole_pkg.
`timescale 1ns / 1ps

module pole_cell import pole_pkg::*; #(
  parameter int CAPACITY   = 64,
  parameter int DATA_WIDTH = 32,
  parameter int INDEX      = 0
) (
  input  logic                             clk,
  input  cell_cmd_t                        cmd,
  input  logic [$clog2(CAPACITY)-1:0]      tgt,
  input  logic [$clog2(CAPACITY+1)-1:0]    cnt,
  input  logic [DATA_WIDTH-1:0]            val,
  input  logic [DATA_WIDTH-1:0]            left_value,
  input  logic [DATA_WIDTH-1:0]            right_value,
  output logic [DATA_WIDTH-1:0]            cell_value,
  input  scan_t                            scan_in,
  input  logic [DATA_WIDTH-1:0]            scan_in_value,
  output scan_t                            scan_out,
  output logic [DATA_WIDTH-1:0]            scan_out_value
);

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [IW-1:0]    MY_IDX  = IW'(INDEX);
  localparam logic [CW-1:0]    MY_CNT  = CW'(INDEX);
  localparam logic [POS_W-1:0] MY_POS  = POS_W'(INDEX + 1);

  logic  match;
  scan_t scan_next;
  logic [DATA_WIDTH-1:0] scan_value_next;

  always_comb begin
    if (cmd.loc) begin
      match = (MY_CNT < cnt) && (cell_value == val);
    end else begin
      match = (MY_IDX == tgt);
    end
    if (!scan_in.hit && match) begin
      scan_next.hit   = 1'b1;
      scan_next.fpos  = MY_POS;
      scan_value_next = cell_value;
    end else begin
      scan_next       = scan_in;
      scan_value_next = scan_in_value;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ins) begin
      if (MY_IDX == tgt) begin
        cell_value <= val;
      end else if (MY_IDX > tgt) begin
        cell_value <= left_value;
      end
    end else if (cmd.del) begin
      if (MY_IDX >= tgt) begin
        cell_value <= right_value;
      end
    end
    scan_out       <= scan_next;
    scan_out_value <= scan_value_next;
  end

endmodule
